### src/key_debounce_repeat_unit_macros.svh
// Assertion macros used by the key debounce and repeat datapath (kdr_core).
`ifndef KEY_DEBOUNCE_REPEAT_UNIT_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define KDR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define KDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/kdr_pkg.sv
// Package: types, codes and helpers of the key debounce and repeat unit.
package kdr_pkg;

   localparam int KEY_WIDTH      = 8;
   localparam int MODE_WIDTH     = 3;
   localparam int TIMER_WIDTH    = 8;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int NUM_KEYS_DEF   = 8;

   // Reset values of the configuration registers
   localparam logic [KEY_WIDTH-1:0]   AUTO_KEYS_RST   = 8'd0;
   localparam logic [TIMER_WIDTH-1:0] FIRST_DELAY_RST = 8'd50;
   localparam logic [TIMER_WIDTH-1:0] LATER_DELAY_RST = 8'd20;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      CSR_AUTO_KEYS   = 2'd0,
      CSR_FIRST_DELAY = 2'd1,
      CSR_LATER_DELAY = 2'd2
   } csr_index_type;

   // Item modes; codes six and seven fall to the default arm
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_TICK   = 3'd0,
      MODE_PRESS  = 3'd1,
      MODE_REPEAT = 3'd2,
      MODE_STATE  = 3'd3,
      MODE_SHORT  = 3'd4,
      MODE_LONG   = 3'd5
   } mode_type;

   // Configuration handed from the register block to the datapath
   typedef struct packed {
      logic [KEY_WIDTH-1:0]   auto_keys;
      logic [TIMER_WIDTH-1:0] first_delay;
      logic [TIMER_WIDTH-1:0] later_delay;
   } cfg_type;

   // Mask of the lanes that carry a key
   function automatic logic [KEY_WIDTH-1:0] lane_mask_f(input int num_keys);
      logic [KEY_WIDTH-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_WIDTH; i++) begin
         m[i] = (i < num_keys);
      end
      return m;
   endfunction

endpackage

### src/kdr_req_if.sv
// Interface: request channel carrying tick and query items.
interface kdr_req_if import kdr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_WIDTH-1:0] mode;
   logic [KEY_WIDTH-1:0]  pin_levels;
   logic [KEY_WIDTH-1:0]  query_keys;

   modport source (output valid, mode, pin_levels, query_keys, input ready);
   modport sink   (input valid, mode, pin_levels, query_keys, output ready);
endinterface

### src/kdr_rsp_if.sv
// Interface: response channel carrying the answer mask.
interface kdr_rsp_if import kdr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_WIDTH-1:0] keys;

   modport source (output valid, keys, input ready);
   modport sink   (input valid, keys, output ready);
endinterface

### src/kdr_csr.sv
// Configuration register block behind the APB-style port.
module kdr_csr import kdr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en = psel && penable && pwrite && pready;

   // Decode the write beat into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_AUTO_KEYS:   cfg_in.auto_keys   = pwdata[KEY_WIDTH-1:0];
            CSR_FIRST_DELAY: cfg_in.first_delay = pwdata[TIMER_WIDTH-1:0];
            CSR_LATER_DELAY: cfg_in.later_delay = pwdata[TIMER_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_keys   <= AUTO_KEYS_RST;
         cfg_ff.first_delay <= FIRST_DELAY_RST;
         cfg_ff.later_delay <= LATER_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register on reads
   always_comb begin
      prdata = '0;
      case (index)
         CSR_AUTO_KEYS:   prdata[KEY_WIDTH-1:0]   = cfg_ff.auto_keys;
         CSR_FIRST_DELAY: prdata[TIMER_WIDTH-1:0] = cfg_ff.first_delay;
         CSR_LATER_DELAY: prdata[TIMER_WIDTH-1:0] = cfg_ff.later_delay;
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### src/kdr_core.sv
// Datapath: input register, debounce and query logic, result register.
module kdr_core import kdr_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   kdr_req_if.sink   req,
   kdr_rsp_if.source rsp
);

`include "key_debounce_repeat_unit_macros.svh"

   localparam logic [KEY_WIDTH-1:0] LANES = lane_mask_f(NUM_KEYS);

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [MODE_WIDTH-1:0] mode_ff;
   logic [KEY_WIDTH-1:0]  pins_ff;
   logic [KEY_WIDTH-1:0]  ask_ff;

   // Result register
   logic                  out_valid_ff, out_valid_in;
   logic [KEY_WIDTH-1:0]  keys_ff, keys_in;

   // Key state
   logic [KEY_WIDTH-1:0]   debounced_ff, debounced_in;
   logic [KEY_WIDTH-1:0]   press_ff, press_in;
   logic [KEY_WIDTH-1:0]   repeat_ff, repeat_in;
   logic [KEY_WIDTH-1:0]   count_low_ff, count_low_in;
   logic [KEY_WIDTH-1:0]   count_high_ff, count_high_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;

   logic accept, advance;
   logic press_clear;

   // Tick and query intermediates
   logic [KEY_WIDTH-1:0]   ask, diff, cl, ch, flip, deb_new, held;
   logic [KEY_WIDTH-1:0]   hit_press, hit_repeat, hit_long;
   logic [TIMER_WIDTH-1:0] timer_base, timer_dec;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign accept      = req.valid && req.ready;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   // Tick and query datapath: vertical counters, toggle, press latch, repeat timer, query hits
   always_comb begin
      ask        = ask_ff & LANES;
      diff       = (debounced_ff ^ ~pins_ff) & LANES;
      cl         = ~(count_low_ff & diff);
      ch         = cl ^ (count_high_ff & diff);
      flip       = diff & cl & ch;
      deb_new    = (debounced_ff ^ flip) & LANES;
      held       = deb_new & cfg.auto_keys & LANES;
      timer_base = (held == '0) ? cfg.first_delay : timer_ff;
      timer_dec  = timer_base - 1'b1;
      hit_press  = ask & press_ff;
      hit_repeat = ask & repeat_ff;
      hit_long   = hit_repeat & press_ff;
   end

   // Next state and answer of the item leaving the input register
   always_comb begin
      debounced_in  = debounced_ff;
      press_in      = press_ff;
      repeat_in     = repeat_ff;
      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      timer_in      = timer_ff;
      keys_in       = keys_ff;
      if (advance) begin
         case (mode_type'(mode_ff))
            MODE_TICK: begin
               count_low_in  = cl;
               count_high_in = ch;
               debounced_in  = deb_new;
               press_in      = press_ff | (deb_new & flip);
               if (timer_dec == '0) begin
                  timer_in  = cfg.later_delay;
                  repeat_in = repeat_ff | held;
               end else begin
                  timer_in = timer_dec;
               end
               keys_in = deb_new;
            end
            MODE_PRESS: begin
               if (hit_press != '0) begin
                  press_in = '0;
               end
               keys_in = hit_press;
            end
            MODE_REPEAT: begin
               repeat_in = repeat_ff ^ hit_repeat;
               keys_in   = hit_repeat;
            end
            MODE_STATE: begin
               keys_in = ask & debounced_ff;
            end
            MODE_SHORT: begin
               if ((hit_press & ~debounced_ff) != '0) begin
                  press_in = '0;
               end
               keys_in = hit_press & ~debounced_ff;
            end
            MODE_LONG: begin
               repeat_in = repeat_ff ^ hit_repeat;
               if (hit_long != '0) begin
                  press_in = '0;
               end
               keys_in = hit_long;
            end
            default: begin
               keys_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         debounced_ff  <= '0;
         press_ff      <= '0;
         repeat_ff     <= '0;
         count_low_ff  <= '0;
         count_high_ff <= '0;
         timer_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         debounced_ff  <= debounced_in;
         press_ff      <= press_in;
         repeat_ff     <= repeat_in;
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
         timer_ff      <= timer_in;
      end
   end

   // Capture the accepted beat; hold payloads while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req.mode;
         pins_ff <= req.pin_levels;
         ask_ff  <= req.query_keys;
      end
      keys_ff <= keys_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.keys  = keys_ff;

   // Flag a press query that hits, for the clearing check
   assign press_clear = advance && (mode_ff == MODE_PRESS) && (hit_press != '0);

   `KDR_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_ff, "result register not loaded")
   `KDR_ASSERT_NEXT(a_stall_holds_in, in_valid_ff && !advance, in_valid_ff, "input beat lost")
   `KDR_ASSERT_NOW(a_lanes_clean, 1'b1, (debounced_ff & ~LANES) == '0, "state outside lanes")
   `KDR_ASSERT_NEXT(a_press_hit_clears, press_clear, press_ff == '0, "press hit did not clear")

endmodule

### src/key_debounce_repeat_unit.sv
// Top level of the eight-lane key debounce and hold-to-repeat unit.
//
//  channel   direction  handshake             payload
//  req_bus   in         valid/ready           mode, pin_levels, query_keys
//  rsp_bus   out        valid/ready           keys
//  apb       in         psel/penable/pready   paddr, pwdata, prdata
//
//  Each item passes through two registers from acceptance to result: the input
//  register, then the result register. The key state is updated as the item leaves
//  the input register, so one item is taken every cycle while the result side keeps up.
//  A stall on the result side holds both registers; the request side stays
//  ready while the input register can drain. Synchronous reset clears all key
//  state and loads the register reset values; no clearing pass is needed.
module key_debounce_repeat_unit import kdr_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   kdr_req_if.sink                   req_bus,
   kdr_rsp_if.source                 rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type cfg;

   // Configuration registers
   kdr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Debounce, repeat and query datapath
   kdr_core #(
      .NUM_KEYS (NUM_KEYS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

### sim/kdr_checker.sv
// Checker for the key debounce unit: predicts the answer to each request beat and compares it.
`timescale 1ns / 100ps
module kdr_checker import kdr_pkg::*; #(
   parameter int NUM_KEYS = NUM_KEYS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   kdr_req_if                        req_mon,
   kdr_rsp_if                        rsp_mon,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic                      pready,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output int                        fail_count,
   output int                        pending,
   output int                        answered
);

   localparam logic [KEY_WIDTH-1:0] LANES =
      (NUM_KEYS >= KEY_WIDTH) ? '1 : KEY_WIDTH'((1 << NUM_KEYS) - 1);
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [MODE_WIDTH-1:0] mode;
      logic [KEY_WIDTH-1:0]  keys;
   } answer_type;

   // Register copies
   logic [KEY_WIDTH-1:0]   rep_mask_q;
   logic [TIMER_WIDTH-1:0] rep_start_q;
   logic [TIMER_WIDTH-1:0] rep_next_q;

   // Key state copies
   logic [KEY_WIDTH-1:0]   deb_q;
   logic [KEY_WIDTH-1:0]   press_q;
   logic [KEY_WIDTH-1:0]   rep_q;
   logic [KEY_WIDTH-1:0]   cnt_lo_q;
   logic [KEY_WIDTH-1:0]   cnt_hi_q;
   logic [TIMER_WIDTH-1:0] timer_q;

   answer_type answers_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      answered   = 0;
   end

   // Count a fault; print only the first few
   task automatic note_fault(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Read-and-clear of press bits: any hit clears the whole latch
   function automatic logic [KEY_WIDTH-1:0] claim_press(input logic [KEY_WIDTH-1:0] ask);
      logic [KEY_WIDTH-1:0] hit;
      hit = ask & press_q;
      if (hit != '0) begin
         press_q = '0;
      end
      return hit;
   endfunction

   // Read-and-clear of repeat bits: only the hit bits are dropped
   function automatic logic [KEY_WIDTH-1:0] claim_repeat(input logic [KEY_WIDTH-1:0] ask);
      logic [KEY_WIDTH-1:0] hit;
      hit = ask & rep_q;
      rep_q = rep_q ^ hit;
      return hit;
   endfunction

   // Sample the pins: advance the vertical counters, debounce, run the repeat timer
   function automatic void sample_pins(input logic [KEY_WIDTH-1:0] pins);
      logic [KEY_WIDTH-1:0] diff;
      logic [KEY_WIDTH-1:0] flip;
      logic [KEY_WIDTH-1:0] held;
      diff     = (deb_q ^ ~pins) & LANES;
      cnt_lo_q = ~(cnt_lo_q & diff);
      cnt_hi_q = cnt_lo_q ^ (cnt_hi_q & diff);
      flip     = diff & cnt_lo_q & cnt_hi_q;
      deb_q    = (deb_q ^ flip) & LANES;
      press_q  = press_q | (deb_q & flip);
      held     = deb_q & rep_mask_q & LANES;
      if (held == '0) begin
         timer_q = rep_start_q;
      end
      timer_q = timer_q - 1'b1;
      if (timer_q == '0) begin
         timer_q = rep_next_q;
         rep_q   = rep_q | held;
      end
   endfunction

   // Work out the answer of one request beat and update the state copies
   function automatic logic [KEY_WIDTH-1:0] predict_keys(input logic [MODE_WIDTH-1:0] mode,
                                                         input logic [KEY_WIDTH-1:0] pins,
                                                         input logic [KEY_WIDTH-1:0] mask);
      logic [KEY_WIDTH-1:0] ask;
      ask = mask & LANES;
      case (mode)
         MODE_TICK: begin
            sample_pins(pins);
            return deb_q;
         end
         MODE_PRESS:  return claim_press(ask);
         MODE_REPEAT: return claim_repeat(ask);
         MODE_STATE:  return ask & deb_q;
         MODE_SHORT:  return claim_press(ask & ~deb_q);
         MODE_LONG:   return claim_press(claim_repeat(ask));
         default:     return '0;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      answer_type due;
      if (reset) begin
         rep_mask_q  = AUTO_KEYS_RST;
         rep_start_q = FIRST_DELAY_RST;
         rep_next_q  = LATER_DELAY_RST;
         deb_q       = '0;
         press_q     = '0;
         rep_q       = '0;
         cnt_lo_q    = '0;
         cnt_hi_q    = '0;
         timer_q     = '0;
         answers_due.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[3:2]))
               CSR_AUTO_KEYS:   rep_mask_q  = pwdata[KEY_WIDTH-1:0];
               CSR_FIRST_DELAY: rep_start_q = pwdata[TIMER_WIDTH-1:0];
               CSR_LATER_DELAY: rep_next_q  = pwdata[TIMER_WIDTH-1:0];
               default: ;
            endcase
         end
         // Compare a response beat with the oldest answer due
         if (rsp_mon.valid && rsp_mon.ready) begin
            answered++;
            if (answers_due.size() == 0) begin
               note_fault($sformatf("unexpected response beat, keys %02h", rsp_mon.keys));
            end else begin
               due = answers_due.pop_front();
               if (rsp_mon.keys !== due.keys) begin
                  note_fault($sformatf("mode %0d answer: expected keys %02h, got %02h",
                                       due.mode, due.keys, rsp_mon.keys));
               end
            end
         end
         // Predict the answer of a request beat
         if (req_mon.valid && req_mon.ready) begin
            due.mode = req_mon.mode;
            due.keys = predict_keys(req_mon.mode, req_mon.pin_levels, req_mon.query_keys);
            answers_due.push_back(due);
         end
      end
      pending = answers_due.size();
   end

endmodule

### sim/tb_key_debounce_repeat_unit.sv
// Testbench top: drives ticks, queries and register writes into the key debounce unit.
`timescale 1ns / 100ps
module tb_key_debounce_repeat_unit;
   import kdr_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int IDLE_PCT     = 28;

   // Codes with no operation behind them
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_HI = 3'd7;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int  fail_count;
   int  pending;
   int  answered;
   int  items_sent;
   int  settings_used;
   int  cycle_count;
   logic calm;

   kdr_req_if req_bus ();
   kdr_rsp_if rsp_bus ();

   key_debounce_repeat_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   kdr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending),
      .answered   (answered)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Stall the response side at random, except in calm stretches
   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Give up after a generous number of cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_key_debounce_repeat_unit: errors");
         $finish;
      end
   end

   // Offer one request beat, with random gaps ahead of it unless calm; enter and leave at a falling edge
   task automatic send_item(input logic [MODE_WIDTH-1:0] mode,
                            input logic [KEY_WIDTH-1:0] pins,
                            input logic [KEY_WIDTH-1:0] mask);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.pin_levels <= pins;
      req_bus.query_keys <= mask;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Write one register: setup, access, then return the bus to idle
   task automatic write_reg(input csr_index_type idx, input logic [TIMER_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {{(CSR_DATA_WIDTH-TIMER_WIDTH){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid and wait for every answer to come back, then idle before returning
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Load a full register setting
   task automatic apply_setting(input logic [KEY_WIDTH-1:0] mask,
                                input logic [TIMER_WIDTH-1:0] start,
                                input logic [TIMER_WIDTH-1:0] gap);
      write_reg(CSR_AUTO_KEYS, mask);
      write_reg(CSR_FIRST_DELAY, start);
      write_reg(CSR_LATER_DELAY, gap);
      settings_used++;
   endtask

   // Random traffic: mostly held pin patterns with queries mixed in, some noise
   task automatic run_phase(input int count, input logic [KEY_WIDTH-1:0] anchor);
      int                    done;
      int                    hold;
      logic [KEY_WIDTH-1:0]  pins;
      logic [KEY_WIDTH-1:0]  ask;
      logic [MODE_WIDTH-1:0] mode;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 99) < 85) begin
            pins = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
            pins = pins & ~anchor;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
            for (int i = 0; i < hold && done < count; i++) begin
               if ($urandom_range(0, 99) < 70) begin
                  send_item(MODE_TICK, pins, 8'($urandom));
               end else begin
                  ask = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
                  mode = MODE_WIDTH'($urandom_range(MODE_LONG, MODE_PRESS));
                  send_item(mode, 8'($urandom), ask);
               end
               done++;
            end
         end else begin
            mode = MODE_WIDTH'($urandom_range(MODE_SPARE_HI, MODE_TICK));
            send_item(mode, 8'($urandom), 8'($urandom));
            if (mode <= MODE_LONG) begin
               done++;
            end
         end
      end
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      calm               = 1'b0;
      cycle_count        = 0;
      items_sent         = 0;
      settings_used      = 0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_TICK;
      req_bus.pin_levels = 8'hFF;
      req_bus.query_keys = 8'h00;
      rsp_bus.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Enable repeat on every key first, so the first held tick wraps the timer from zero
      write_reg(CSR_AUTO_KEYS, 8'hFF);
      settings_used++;

      // All keys pressed: counters start at zero, so the state flips at once
      send_item(MODE_TICK, 8'h00, 8'h00);
      send_item(MODE_STATE, 8'hFF, 8'hFF);
      send_item(MODE_PRESS, 8'hFF, 8'h01);
      send_item(MODE_PRESS, 8'h00, 8'hFF);
      repeat (2) send_item(MODE_TICK, 8'h00, 8'hFF);
      send_item(MODE_REPEAT, 8'h00, 8'hFF);
      send_item(MODE_SHORT, 8'hFF, 8'hFF);
      send_item(MODE_LONG, 8'h00, 8'hFF);
      // Release everything: four disagreeing ticks are needed now
      repeat (5) send_item(MODE_TICK, 8'hFF, 8'h00);
      send_item(MODE_STATE, 8'h00, 8'hFF);
      send_item(MODE_SHORT, 8'h00, 8'hFF);
      repeat (4) send_item(MODE_TICK, 8'hAA, 8'hFF);
      send_item(MODE_PRESS, 8'hFF, 8'hFF);
      send_item(MODE_LONG, 8'hFF, 8'h0F);
      // Codes with no operation change nothing
      send_item(MODE_SPARE_LO, 8'h00, 8'hFF);
      send_item(MODE_SPARE_HI, 8'hFF, 8'hFF);
      send_item(MODE_STATE, 8'h55, 8'h00);
      settle();

      // Shortest delays, every key repeating
      apply_setting(8'hFF, 8'd1, 8'd1);
      run_phase(120, 8'h00);
      settle();

      // Longest delays, no repeat keys; no stalls on either side
      apply_setting(8'h00, 8'd255, 8'd255);
      calm = 1'b1;
      run_phase(80, 8'h00);
      settle();
      calm = 1'b0;

      // Mid-range delays on a sparse mask
      apply_setting(8'hA5, 8'd4, 8'd2);
      run_phase(140, 8'h00);
      settle();

      // Zero delays wrap the timer; hold two repeat keys long enough to see it expire
      apply_setting(8'h5A, 8'd0, 8'd0);
      run_phase(420, 8'h18);
      settle();
      repeat (8) @(negedge clock);

      $display("Sent %0d items under %0d register settings; %0d answers compared.",
               items_sent, settings_used, answered);
      $display("Covered debounce flips, press/repeat read-and-clear, spare codes, timer wrap.");
      if (fail_count == 0) begin
         $display("tb_key_debounce_repeat_unit: clean");
      end else begin
         $display("tb_key_debounce_repeat_unit: errors");
      end
      $finish;
   end

endmodule
